FILE: hdl/fwl_pkg.sv
// ----------------------------------------------------------------------------
// fwl_pkg
// shared types, codes and constants of the flash translation wear leveler
// ----------------------------------------------------------------------------
package fwl_pkg;

	// fixed field widths
	localparam int CMD_W      = 2;
	localparam int LB_W       = 5;
	localparam int BLK_W      = 5;
	localparam int OP_W       = 3;
	localparam int THR_W      = 16;
	localparam int LOG_BLOCKS = 32;

	// parameter defaults
	localparam int PHYS_BLOCKS_DEF = 32;
	localparam int COUNT_BITS_DEF  = 16;

	localparam logic [THR_W-1:0] THR_RESET = 16'd5;

	// host commands
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TRIM  = 2'd2;

	// flash operations
	localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
	localparam logic [OP_W-1:0] OP_READ  = 3'd1;
	localparam logic [OP_W-1:0] OP_WRITE = 3'd2;
	localparam logic [OP_W-1:0] OP_ERASE = 3'd3;
	localparam logic [OP_W-1:0] OP_COPY  = 3'd4;

	// kinds of result word built by the datapath
	localparam logic [2:0] EM_NONE     = 3'd0;
	localparam logic [2:0] EM_UNMAPPED = 3'd1;
	localparam logic [2:0] EM_READ     = 3'd2;
	localparam logic [2:0] EM_ERASE    = 3'd3;
	localparam logic [2:0] EM_COPY     = 3'd4;
	localparam logic [2:0] EM_COLD     = 3'd5;
	localparam logic [2:0] EM_WRITE    = 3'd6;

	// table updates done with a result word
	localparam logic [2:0] UPD_NONE  = 3'd0;
	localparam logic [2:0] UPD_ERASE = 3'd1;
	localparam logic [2:0] UPD_COPY  = 3'd2;
	localparam logic [2:0] UPD_COLD  = 3'd3;
	localparam logic [2:0] UPD_FREE  = 3'd4;

	typedef struct packed {
		logic       take;
		logic       scan_start;
		logic       emit;
		logic [2:0] emit_kind;
		logic       last;
		logic [2:0] upd;
	} fwl_ctl_t;

	typedef struct packed {
		logic             clr_done;
		logic             slot_free;
		logic [CMD_W-1:0] cmd;
		logic             map_valid;
		logic             scan_last;
		logic             free_found;
		logic             migrate;
	} fwl_stat_t;

endpackage

FILE: hdl/fwl_if.sv
// ----------------------------------------------------------------------------
// fwl_if
// valid/ready channels for host commands and flash operation words
// ----------------------------------------------------------------------------
interface fwl_req_if import fwl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic [LB_W-1:0]  logical_block;

	modport source(output valid, cmd, logical_block, input ready);
	modport sink(input valid, cmd, logical_block, output ready);
endinterface

interface fwl_rsp_if import fwl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  flash_op;
	logic [BLK_W-1:0] target_block;
	logic [BLK_W-1:0] source_block;
	logic             status;
	logic             last;

	modport source(output valid, flash_op, target_block, source_block, status, last,
		input ready);
	modport sink(input valid, flash_op, target_block, source_block, status, last,
		output ready);
endinterface

FILE: hdl/fwl_ctrl.sv
// ----------------------------------------------------------------------------
// fwl_ctrl
// command sequencer: steps each host command through its flash operations
// ----------------------------------------------------------------------------
module fwl_ctrl import fwl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      ready,
	output fwl_ctl_t  ctl,
	input  fwl_stat_t stat
);

	localparam logic [2:0] S_CLEAR    = 3'd0;
	localparam logic [2:0] S_IDLE     = 3'd1;
	localparam logic [2:0] S_DISPATCH = 3'd2;
	localparam logic [2:0] S_ERASE    = 3'd3;
	localparam logic [2:0] S_SCAN     = 3'd4;
	localparam logic [2:0] S_DECIDE   = 3'd5;
	localparam logic [2:0] S_COLD     = 3'd6;
	localparam logic [2:0] S_FINAL    = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign ready = (state_q == S_IDLE);

	always_comb begin
		ctl       = '0;
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: begin
				if (stat.clr_done) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					ctl.take  = 1'b1;
					state_nxt = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (stat.cmd)
					CMD_READ: begin
						if (stat.slot_free) begin
							ctl.emit      = 1'b1;
							ctl.emit_kind = stat.map_valid ? EM_READ : EM_UNMAPPED;
							ctl.last      = 1'b1;
							state_nxt     = S_IDLE;
						end
					end
					CMD_WRITE: begin
						if (stat.map_valid) begin
							state_nxt = S_ERASE;
						end else begin
							ctl.scan_start = 1'b1;
							state_nxt      = S_SCAN;
						end
					end
					CMD_TRIM: begin
						if (stat.map_valid) begin
							state_nxt = S_ERASE;
						end else if (stat.slot_free) begin
							ctl.emit      = 1'b1;
							ctl.emit_kind = EM_NONE;
							ctl.last      = 1'b1;
							state_nxt     = S_IDLE;
						end
					end
					default: begin
						if (stat.slot_free) begin
							ctl.emit      = 1'b1;
							ctl.emit_kind = EM_NONE;
							ctl.last      = 1'b1;
							state_nxt     = S_IDLE;
						end
					end
				endcase
			end
			S_ERASE: begin
				if (stat.slot_free) begin
					ctl.emit      = 1'b1;
					ctl.emit_kind = EM_ERASE;
					ctl.upd       = UPD_ERASE;
					if (stat.cmd == CMD_WRITE) begin
						ctl.scan_start = 1'b1;
						state_nxt      = S_SCAN;
					end else begin
						ctl.last  = 1'b1;
						state_nxt = S_IDLE;
					end
				end
			end
			S_SCAN: begin
				if (stat.scan_last) state_nxt = S_DECIDE;
			end
			S_DECIDE: begin
				if (stat.slot_free) begin
					ctl.emit = 1'b1;
					if (!stat.free_found) begin
						ctl.emit_kind = EM_UNMAPPED;
						ctl.last      = 1'b1;
						state_nxt     = S_IDLE;
					end else if (stat.migrate) begin
						ctl.emit_kind = EM_COPY;
						ctl.upd       = UPD_COPY;
						state_nxt     = S_COLD;
					end else begin
						ctl.emit_kind = EM_WRITE;
						ctl.upd       = UPD_FREE;
						ctl.last      = 1'b1;
						state_nxt     = S_IDLE;
					end
				end
			end
			S_COLD: begin
				if (stat.slot_free) begin
					ctl.emit      = 1'b1;
					ctl.emit_kind = EM_COLD;
					ctl.upd       = UPD_COLD;
					state_nxt     = S_FINAL;
				end
			end
			S_FINAL: begin
				if (stat.slot_free) begin
					ctl.emit      = 1'b1;
					ctl.emit_kind = EM_WRITE;
					ctl.last      = 1'b1;
					state_nxt     = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

FILE: hdl/fwl_dp.sv
// ----------------------------------------------------------------------------
// fwl_dp
// block tables, erase count memory with min scan, and output word register
// ----------------------------------------------------------------------------
module fwl_dp import fwl_pkg::*; #(
	parameter int PHYS_BLOCKS = PHYS_BLOCKS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fwl_ctl_t         ctl,
	output fwl_stat_t        stat,
	input  logic             wear_threshold_we,
	input  logic [THR_W-1:0] wear_threshold,
	input  logic [CMD_W-1:0] req_cmd,
	input  logic [LB_W-1:0]  req_lb,
	fwl_rsp_if.source        rsp
);

	localparam int PB_W  = $clog2(PHYS_BLOCKS);
	localparam int CW    = COUNT_BITS;
	localparam int CMP_W = (CW > THR_W) ? CW : THR_W;
	localparam int EXT_W = (PB_W > BLK_W) ? PB_W : BLK_W;
	localparam logic [PB_W-1:0] LAST_IDX = PB_W'(PHYS_BLOCKS - 1);

	typedef logic [PB_W-1:0] pidx_t;
	typedef logic [CW-1:0]   cnt_t;

	function automatic cnt_t sat_inc(input cnt_t v);
		sat_inc = (v == {CW{1'b1}}) ? v : v + CW'(1);
	endfunction

	function automatic logic [BLK_W-1:0] to_blk(input pidx_t b);
		logic [EXT_W-1:0] w;
		w      = EXT_W'(b);
		to_blk = w[BLK_W-1:0];
	endfunction

	// in-use flag on top of the erase count
	logic [CW:0] mem [PHYS_BLOCKS];
	logic [CW:0] rdata_q;

	logic [THR_W-1:0] thr_q;
	logic [CMD_W-1:0] cmd_q;
	logic [LB_W-1:0]  lb_q;

	logic  map_vld_q [LOG_BLOCKS];
	pidx_t map_q     [LOG_BLOCKS];

	logic  clr_run_q, scan_run_q;
	pidx_t idx_q;
	logic  cmp_vld_s1, cmp_last_s1;
	pidx_t cmp_idx_s1;

	logic  ffound_q, ufound_q;
	cnt_t  fmin_q, umin_q;
	pidx_t fidx_q, uidx_q;

	logic             out_vld_q;
	logic [OP_W-1:0]  out_op_q;
	logic [BLK_W-1:0] out_tgt_q, out_src_q;
	logic             out_st_q, out_last_q;

	pidx_t       cur_blk, rd_addr, wr_addr, final_blk;
	logic        cur_vld, mem_we, migrate, slot_free;
	logic [CW:0] wr_data;
	logic [OP_W-1:0]  nxt_op;
	logic [BLK_W-1:0] nxt_tgt, nxt_src;
	logic             nxt_st;

	assign cur_blk   = map_q[lb_q];
	assign cur_vld   = map_vld_q[lb_q];
	assign rd_addr   = scan_run_q ? idx_q : cur_blk;
	assign migrate   = ffound_q && ufound_q && (CMP_W'(fmin_q) >= CMP_W'(thr_q));
	assign final_blk = migrate ? uidx_q : fidx_q;
	assign slot_free = !out_vld_q || rsp.ready;

	// write port: clearing sweep first, then the table update of the word
	always_comb begin
		mem_we  = 1'b0;
		wr_addr = cur_blk;
		wr_data = '0;
		if (clr_run_q) begin
			mem_we  = 1'b1;
			wr_addr = idx_q;
		end else if (ctl.emit) begin
			case (ctl.upd)
				UPD_ERASE: begin
					mem_we  = 1'b1;
					wr_addr = cur_blk;
					wr_data = {1'b0, sat_inc(rdata_q[CW-1:0])};
				end
				UPD_COPY: begin
					mem_we  = 1'b1;
					wr_addr = fidx_q;
					wr_data = {1'b1, sat_inc(fmin_q)};
				end
				UPD_COLD: begin
					mem_we  = 1'b1;
					wr_addr = uidx_q;
					wr_data = {1'b1, sat_inc(umin_q)};
				end
				UPD_FREE: begin
					mem_we  = 1'b1;
					wr_addr = fidx_q;
					wr_data = {1'b1, fmin_q};
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= wr_data;
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (wear_threshold_we) begin
			thr_q <= wear_threshold;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			cmd_q <= req_cmd;
			lb_q  <= req_lb;
		end
	end

	// logical map valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LOG_BLOCKS; i++) map_vld_q[i] <= 1'b0;
		end else if (ctl.emit) begin
			case (ctl.upd)
				UPD_ERASE: map_vld_q[lb_q] <= 1'b0;
				UPD_COLD:  map_vld_q[lb_q] <= 1'b1;
				UPD_FREE:  map_vld_q[lb_q] <= 1'b1;
				default:   map_vld_q[lb_q] <= map_vld_q[lb_q];
			endcase
		end
	end

	// logical map entries, cold block owner follows its data to the copy
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			case (ctl.upd)
				UPD_COLD: begin
					for (int i = 0; i < LOG_BLOCKS; i++) begin
						if (map_vld_q[i] && map_q[i] == uidx_q) map_q[i] <= fidx_q;
					end
					map_q[lb_q] <= uidx_q;
				end
				UPD_FREE: map_q[lb_q] <= fidx_q;
				default:  map_q[lb_q] <= map_q[lb_q];
			endcase
		end
	end

	// sweep counter for clearing and scanning
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_run_q   <= 1'b1;
			scan_run_q  <= 1'b0;
			idx_q       <= '0;
			cmp_vld_s1  <= 1'b0;
			cmp_last_s1 <= 1'b0;
			cmp_idx_s1  <= '0;
		end else begin
			cmp_vld_s1  <= scan_run_q;
			cmp_last_s1 <= (idx_q == LAST_IDX);
			cmp_idx_s1  <= idx_q;
			if (clr_run_q) begin
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + PB_W'(1);
				if (idx_q == LAST_IDX) clr_run_q <= 1'b0;
			end else if (ctl.scan_start) begin
				idx_q      <= '0;
				scan_run_q <= 1'b1;
			end else if (scan_run_q) begin
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + PB_W'(1);
				if (idx_q == LAST_IDX) scan_run_q <= 1'b0;
			end
		end
	end

	// running minima, lowest index wins a tie
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ffound_q <= 1'b0;
			ufound_q <= 1'b0;
			fmin_q   <= '0;
			umin_q   <= '0;
			fidx_q   <= '0;
			uidx_q   <= '0;
		end else if (ctl.scan_start) begin
			ffound_q <= 1'b0;
			ufound_q <= 1'b0;
		end else if (cmp_vld_s1) begin
			if (!rdata_q[CW]) begin
				if (!ffound_q || rdata_q[CW-1:0] < fmin_q) begin
					ffound_q <= 1'b1;
					fmin_q   <= rdata_q[CW-1:0];
					fidx_q   <= cmp_idx_s1;
				end
			end else begin
				if (!ufound_q || rdata_q[CW-1:0] < umin_q) begin
					ufound_q <= 1'b1;
					umin_q   <= rdata_q[CW-1:0];
					uidx_q   <= cmp_idx_s1;
				end
			end
		end
	end

	// next output word
	always_comb begin
		nxt_op  = OP_NONE;
		nxt_tgt = '0;
		nxt_src = '0;
		nxt_st  = 1'b0;
		case (ctl.emit_kind)
			EM_UNMAPPED: nxt_st = 1'b1;
			EM_READ: begin
				nxt_op  = OP_READ;
				nxt_tgt = to_blk(cur_blk);
			end
			EM_ERASE: begin
				nxt_op  = OP_ERASE;
				nxt_tgt = to_blk(cur_blk);
			end
			EM_COPY: begin
				nxt_op  = OP_COPY;
				nxt_tgt = to_blk(fidx_q);
				nxt_src = to_blk(uidx_q);
			end
			EM_COLD: begin
				nxt_op  = OP_ERASE;
				nxt_tgt = to_blk(uidx_q);
			end
			EM_WRITE: begin
				nxt_op  = OP_WRITE;
				nxt_tgt = to_blk(final_blk);
			end
			default: nxt_op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctl.emit) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_op_q   <= nxt_op;
			out_tgt_q  <= nxt_tgt;
			out_src_q  <= nxt_src;
			out_st_q   <= nxt_st;
			out_last_q <= ctl.last;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.flash_op     = out_op_q;
	assign rsp.target_block = out_tgt_q;
	assign rsp.source_block = out_src_q;
	assign rsp.status       = out_st_q;
	assign rsp.last         = out_last_q;

	assign stat.clr_done   = !clr_run_q;
	assign stat.slot_free  = slot_free;
	assign stat.cmd        = cmd_q;
	assign stat.map_valid  = cur_vld;
	assign stat.scan_last  = cmp_vld_s1 && cmp_last_s1;
	assign stat.free_found = ffound_q;
	assign stat.migrate    = migrate;

endmodule

FILE: hdl/flash_translation_wear_leveler.sv
// a read, a trim of an unmapped block or an unused command gives its word from the dispatch
//   state once it is taken, an erasing trim passes through the erase state first
// a write gives its last word after one pass over the erase count memory
//   through its single registered read port
// one command at a time: the next is taken the cycle after its last word is loaded
// reset: after arst_n releases, a clearing pass zeroes the memory
// ----------------------------------------------------------------------------
// flash_translation_wear_leveler
// logical to physical block map with wear leveling by cold data migration
// ----------------------------------------------------------------------------
module flash_translation_wear_leveler import fwl_pkg::*; #(
	parameter int PHYS_BLOCKS = PHYS_BLOCKS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	fwl_req_if.sink          req,
	fwl_rsp_if.source        rsp,
	input  logic             wear_threshold_we,
	input  logic [THR_W-1:0] wear_threshold
);

	// controller and datapath talk only through these two structs
	fwl_ctl_t  ctl_w;
	fwl_stat_t stat_w;
	logic      req_ready_w;

	// sequencer: one command word in, one to four operation words out
	fwl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.ready     (req_ready_w),
		.ctl       (ctl_w),
		.stat      (stat_w)
	);

	// command is latched when taken, so the word may change right after
	assign req.ready = req_ready_w;

	// tables, count memory, scan for least worn free and in-use blocks,
	// and the output register that lets a stalled word wait
	fwl_dp #(
		.PHYS_BLOCKS (PHYS_BLOCKS),
		.COUNT_BITS  (COUNT_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl               (ctl_w),
		.stat              (stat_w),
		.wear_threshold_we (wear_threshold_we),
		.wear_threshold    (wear_threshold),
		.req_cmd           (req.cmd),
		.req_lb            (req.logical_block),
		.rsp               (rsp)
	);

endmodule

FILE: hdl/fwl_chk.sv
// ----------------------------------------------------------------------------
// fwl_chk
// port level checks of the wear leveler, bound to the top level
// ----------------------------------------------------------------------------
module fwl_chk import fwl_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [OP_W-1:0]  flash_op,
	input logic [BLK_W-1:0] target_block,
	input logic [BLK_W-1:0] source_block,
	input logic             status,
	input logic             last
);

	// stalled word stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("output word dropped while stalled");

	// one command at a time
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("command taken while another is in work");

	// a no-op word closes its command and names no block
	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && flash_op == OP_NONE |-> last && target_block == '0 && source_block == '0)
		else $error("no-op word malformed");

	a_src_copy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && flash_op != OP_COPY |-> source_block == '0)
		else $error("source block set outside copy");

	a_err_none: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status |-> flash_op == OP_NONE)
		else $error("error status on a real operation");

endmodule

bind flash_translation_wear_leveler fwl_chk u_fwl_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.flash_op     (rsp.flash_op),
	.target_block (rsp.target_block),
	.source_block (rsp.source_block),
	.status       (rsp.status),
	.last         (rsp.last)
);

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for flash_translation_wear_leveler: host commands go in
// over the request channel, a block-level map and wear model predicts the
// flash operation words, and every word taken from the response channel is
// compared field by field against the oldest prediction
// ----------------------------------------------------------------------------
module testbench import fwl_pkg::*;;

	// bench constants
	localparam int          PHYS          = PHYS_BLOCKS_DEF;
	localparam int          CNT_W         = COUNT_BITS_DEF;
	localparam int          IDLE_PCT      = 7;
	localparam int          PHASE_SETTLE  = 16;
	localparam int          END_SETTLE    = 64;
	localparam int          HOLD_CYCLES   = 300;
	localparam int unsigned CYCLE_LIMIT   = 200000;

	// command code the package leaves unnamed
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// status codes
	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FAIL = 1'b1;

	// one flash operation word as seen on the response channel
	typedef struct {
		logic [OP_W-1:0]  flash_op;
		logic [BLK_W-1:0] target_block;
		logic [BLK_W-1:0] source_block;
		logic             status;
		logic             last;
	} flash_word_t;

	logic clk;
	logic arst_n;
	logic             thr_we;
	logic [THR_W-1:0] thr_data;

	fwl_req_if req_ch ();
	fwl_rsp_if rsp_ch ();

	flash_translation_wear_leveler u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.req               (req_ch),
		.rsp               (rsp_ch),
		.wear_threshold_we (thr_we),
		.wear_threshold    (thr_data)
	);

	// shadow of the block's tables, updated as each command is taken
	logic             map_ok   [LOG_BLOCKS];
	logic [BLK_W-1:0] map_phys [LOG_BLOCKS];
	logic             busy_blk [PHYS];
	logic [CNT_W-1:0] wear     [PHYS];
	logic [THR_W-1:0] wear_limit;

	// flash words still owed by the block, oldest first
	flash_word_t pending_ops[$];

	int          mismatch_count;
	int unsigned cycle_count;
	bit          idle_on;
	int          hold_request;

	// ------------------------------------------------------------------------
	// clock
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// shadow model of the translation layer
	// ------------------------------------------------------------------------

	// queue one expected word; last is fixed up once the command is complete
	function automatic void push_op(input logic [OP_W-1:0] op, input int tgt, input int src,
		input logic st);
		flash_word_t w;
		w.flash_op     = op;
		w.target_block = tgt[BLK_W-1:0];
		w.source_block = src[BLK_W-1:0];
		w.status       = st;
		w.last         = 1'b0;
		pending_ops.push_back(w);
	endfunction

	// erase counters stick at all ones
	function automatic void bump_wear(input int b);
		if (wear[b] != '1)
			wear[b] = wear[b] + 1'b1;
	endfunction

	function automatic void wipe_block(input int b);
		push_op(OP_ERASE, b, 0, ST_OK);
		bump_wear(b);
		busy_blk[b] = 1'b0;
	endfunction

	// least worn block whose in-use flag equals want; ties go to the lowest index
	function automatic bit least_worn(input logic want, output int which);
		bit               found;
		logic [CNT_W-1:0] best;
		found = 1'b0;
		best  = '0;
		which = 0;
		for (int i = 0; i < PHYS; i++) begin
			if (busy_blk[i] == want && (!found || wear[i] < best)) begin
				found = 1'b1;
				best  = wear[i];
				which = i;
			end
		end
		return found;
	endfunction

	function automatic void predict_command(input logic [CMD_W-1:0] c,
		input logic [LB_W-1:0] lb);
		int fb;
		int cold;
		fb   = 0;
		cold = 0;
		case (c)
			CMD_READ: begin
				if (map_ok[lb])
					push_op(OP_READ, int'(map_phys[lb]), 0, ST_OK);
				else
					push_op(OP_NONE, 0, 0, ST_FAIL);
			end
			CMD_WRITE: begin
				// old copy goes first, even if nothing can be allocated after
				if (map_ok[lb]) begin
					wipe_block(int'(map_phys[lb]));
					map_ok[lb] = 1'b0;
				end
				if (!least_worn(1'b0, fb)) begin
					push_op(OP_NONE, 0, 0, ST_FAIL);
				end else begin
					// worn free block: park cold data there and reuse the cold block
					if (wear[fb] >= wear_limit && least_worn(1'b1, cold)) begin
						push_op(OP_COPY, fb, cold, ST_OK);
						bump_wear(fb);
						busy_blk[fb] = 1'b1;
						for (int i = 0; i < LOG_BLOCKS; i++)
							if (map_ok[i] && map_phys[i] == cold)
								map_phys[i] = fb[BLK_W-1:0];
						wipe_block(cold);
						fb = cold;
					end
					map_ok[lb]   = 1'b1;
					map_phys[lb] = fb[BLK_W-1:0];
					busy_blk[fb] = 1'b1;
					push_op(OP_WRITE, fb, 0, ST_OK);
				end
			end
			CMD_TRIM: begin
				if (map_ok[lb]) begin
					wipe_block(int'(map_phys[lb]));
					map_ok[lb] = 1'b0;
				end else begin
					push_op(OP_NONE, 0, 0, ST_OK);
				end
			end
			default: push_op(OP_NONE, 0, 0, ST_OK);
		endcase
		pending_ops[pending_ops.size()-1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------------
	// response side: ready with random gaps, plus an occasional long hold-off
	// ------------------------------------------------------------------------
	initial begin
		int hold_len;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				// hold the sink shut and let the block back up into the host side
				hold_len     = hold_request;
				hold_request = 0;
				rsp_ch.ready <= 1'b0;
				repeat (hold_len - 1) @(negedge clk);
			end else begin
				rsp_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// ------------------------------------------------------------------------
	// word checker
	// ------------------------------------------------------------------------
	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		flash_word_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_ops.size() == 0) begin
				$error("flash word with no command pending: op %0d target %0d",
					rsp_ch.flash_op, rsp_ch.target_block);
				mismatch_count++;
			end else begin
				want = pending_ops.pop_front();
				check_field("flash_op", 8'(want.flash_op), 8'(rsp_ch.flash_op));
				check_field("target_block", 8'(want.target_block),
					8'(rsp_ch.target_block));
				check_field("source_block", 8'(want.source_block),
					8'(rsp_ch.source_block));
				check_field("status", 8'(want.status), 8'(rsp_ch.status));
				check_field("last", 8'(want.last), 8'(rsp_ch.last));
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog
	// ------------------------------------------------------------------------
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// host side helpers, all entered and left at a falling edge
	// ------------------------------------------------------------------------

	// offer one command word and predict its flash words once it is taken;
	// valid stays up on return so a back-to-back call keeps it high
	task automatic send_command(input logic [CMD_W-1:0] c, input logic [LB_W-1:0] lb);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.cmd           <= c;
		req_ch.logical_block <= lb;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predict_command(c, lb);
		@(negedge clk);
	endtask

	// drop valid and wait until every owed word has come back
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (pending_ops.size() != 0)
			@(negedge clk);
		repeat (PHASE_SETTLE) @(negedge clk);
	endtask

	// only called with the block idle
	task automatic set_threshold(input logic [THR_W-1:0] value);
		thr_we   <= 1'b1;
		thr_data <= value;
		@(negedge clk);
		thr_we     <= 1'b0;
		wear_limit = value;
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// nothing mapped yet: unmapped read, unmapped trim, unused command code
	task automatic test_unmapped_commands();
		send_command(CMD_READ, 5'd0);
		send_command(CMD_TRIM, 5'd31);
		send_command(CMD_UNUSED, 5'd21);
		send_command(CMD_READ, 5'd10);
		wait_idle();
	endtask

	// threshold zero: first write finds nothing in use and takes the free block,
	// every later write migrates
	task automatic test_threshold_zero();
		set_threshold('0);
		send_command(CMD_WRITE, 5'd3);
		send_command(CMD_WRITE, 5'd4);
		send_command(CMD_READ, 5'd3);
		send_command(CMD_READ, 5'd4);
		send_command(CMD_WRITE, 5'd3);
		wait_idle();
	endtask

	// plain mapping at the reset threshold, lowest and highest logical blocks
	task automatic test_basic_mapping();
		set_threshold(THR_RESET);
		send_command(CMD_WRITE, 5'd0);
		send_command(CMD_WRITE, 5'd31);
		send_command(CMD_READ, 5'd0);
		send_command(CMD_READ, 5'd31);
		send_command(CMD_WRITE, 5'd0);
		send_command(CMD_TRIM, 5'd31);
		send_command(CMD_READ, 5'd31);
		send_command(CMD_TRIM, 5'd3);
		send_command(CMD_TRIM, 5'd4);
		send_command(CMD_TRIM, 5'd0);
		wait_idle();
	endtask

	// threshold one and the highest threshold
	task automatic test_threshold_extremes();
		set_threshold(16'd1);
		send_command(CMD_WRITE, 5'd7);
		send_command(CMD_WRITE, 5'd8);
		send_command(CMD_WRITE, 5'd7);
		wait_idle();
		set_threshold(16'hFFFF);
		send_command(CMD_WRITE, 5'd9);
		send_command(CMD_WRITE, 5'd9);
		send_command(CMD_READ, 5'd9);
		wait_idle();
	endtask

	// writes half the time, aimed at a hot set of logical blocks so erase counts climb
	// and migration kicks in
	task automatic test_random_traffic(input logic [THR_W-1:0] thr, input int count);
		int               pick;
		logic [CMD_W-1:0] c;
		logic [LB_W-1:0]  lb;
		set_threshold(thr);
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			if (pick < 50)
				c = CMD_WRITE;
			else if (pick < 78)
				c = CMD_READ;
			else if (pick < 95)
				c = CMD_TRIM;
			else
				c = CMD_UNUSED;
			if ($urandom_range(99) < 60)
				lb = LB_W'($urandom_range(7));
			else
				lb = LB_W'($urandom_range(31));
			send_command(c, lb);
		end
		wait_idle();
	endtask

	// sink shut for a long stretch while commands keep coming
	task automatic test_backpressure();
		idle_on      = 1'b0;
		hold_request = HOLD_CYCLES;
		for (int k = 0; k < 20; k++)
			send_command(($urandom_range(1) != 0) ? CMD_WRITE : CMD_READ,
				LB_W'($urandom_range(31)));
		wait_idle();
		idle_on = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		mismatch_count       = 0;
		hold_request         = 0;
		idle_on              = 1'b1;
		arst_n               = 1'b0;
		thr_we               = 1'b0;
		thr_data             = '0;
		req_ch.valid         = 1'b0;
		req_ch.cmd           = CMD_READ;
		req_ch.logical_block = '0;
		wear_limit           = THR_RESET;
		for (int i = 0; i < LOG_BLOCKS; i++) begin
			map_ok[i]   = 1'b0;
			map_phys[i] = '0;
		end
		for (int i = 0; i < PHYS; i++) begin
			busy_blk[i] = 1'b0;
			wear[i]     = '0;
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// the block clears its erase count memory after reset; send_command waits on ready
		test_unmapped_commands();
		test_threshold_zero();
		test_basic_mapping();
		test_threshold_extremes();

		test_random_traffic(THR_RESET, 32);
		test_random_traffic(16'd1, 32);
		idle_on = 1'b0;
		test_random_traffic(16'd2, 32);
		idle_on = 1'b1;
		test_random_traffic(16'hFFFF, 32);
		test_random_traffic(THR_W'($urandom_range(12, 3)), 32);
		test_backpressure();

		repeat (END_SETTLE) @(negedge clk);
		if (mismatch_count == 0 && pending_ops.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
